/* hw/rtl/gif_frame_compositor_assert.svh */
// ----------------------------------------------------------------------------
// gif_frame_compositor_assert.svh
// Assertion macros for the compositor; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef GIF_FRAME_COMPOSITOR_ASSERT_SVH
`define GIF_FRAME_COMPOSITOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GFC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("gif_frame_compositor: assertion failed");

// next-cycle implication
`define GFC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("gif_frame_compositor: assertion failed");

`else

`define GFC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define GFC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

/* hw/rtl/gfc_pkg.sv */
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared types and constants of the GIF frame compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package gfc_pkg;

	// item opcodes
	typedef enum logic [2:0] {
		OP_RESTART = 3'd0,
		OP_PALETTE = 3'd1,
		OP_FRAME   = 3'd2,
		OP_PIXEL   = 3'd3,
		OP_READ    = 3'd4
	} opcode_t;

	// disposal methods that act
	localparam logic [2:0] DISP_CLEAR   = 3'd2;
	localparam logic [2:0] DISP_RESTORE = 3'd3;

	// configuration register indexes
	localparam logic REG_CANVAS_W = 1'b0;
	localparam logic REG_CANVAS_H = 1'b1;

	localparam logic [9:0] CFG_DIM_RESET = 10'd512;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'hff;

	// memory sweep kinds
	typedef enum logic [1:0] {
		SW_CLEAR_ALL  = 2'd0,
		SW_CLEAR_RECT = 2'd1,
		SW_RESTORE    = 2'd2,
		SW_SNAP       = 2'd3
	} sweep_mode_t;

	typedef enum logic [2:0] {
		ST_BOOT,
		ST_IDLE,
		ST_RESTART,
		ST_DISPOSE,
		ST_SNAP,
		ST_PIXEL
	} state_t;

	typedef struct packed {
		logic        sweep_start;
		sweep_mode_t sweep_mode;
		logic        load_frame;
		logic        load_palette;
		logic        pix_go;
		logic        read_go;
		logic        restart;
	} gfc_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic rect_empty;
	} gfc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/gfc_ctrl.sv */
// ----------------------------------------------------------------------------
// gfc_ctrl
// Sequencer: accepts items, orders disposal, snapshot and canvas sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2:0]        opcode,
	input  wire logic [2:0]        disposal,
	output logic                   busy,
	output gfc_pkg::gfc_cmd_t      cmd,
	input  wire gfc_pkg::gfc_status_t status
);
	import gfc_pkg::*;

	state_t     state_q, state_d;
	logic       held_q, have_prior_q, snap_pend_q;
	logic [2:0] prior_disp_q;
	logic       accept, disp_clear, disp_restore, snap_need;
	opcode_t    op;

	assign op           = opcode_t'(opcode);
	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && (state_q == ST_IDLE);
	assign disp_clear   = have_prior_q && (prior_disp_q == DISP_CLEAR) && !status.rect_empty;
	assign disp_restore = have_prior_q && (prior_disp_q == DISP_RESTORE);
	assign snap_need    = (disposal == DISP_RESTORE) && !held_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

	// frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= 1'b0;
			have_prior_q <= 1'b0;
			snap_pend_q  <= 1'b0;
			prior_disp_q <= 3'd0;
		end else if (accept && op == OP_RESTART) begin
			held_q       <= 1'b0;
			have_prior_q <= 1'b0;
		end else if (accept && op == OP_FRAME) begin
			held_q       <= (disposal == DISP_RESTORE);
			have_prior_q <= 1'b1;
			snap_pend_q  <= snap_need;
			prior_disp_q <= disposal;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_BOOT: begin
				state_d = ST_RESTART;
			end
			ST_IDLE: begin
				if (start) begin
					case (op)
						OP_RESTART: state_d = ST_RESTART;
						OP_FRAME: begin
							if (disp_clear || disp_restore) state_d = ST_DISPOSE;
							else if (snap_need)             state_d = ST_SNAP;
							else                            state_d = ST_IDLE;
						end
						OP_PIXEL: state_d = ST_PIXEL;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_RESTART: begin
				if (status.sweep_done) state_d = ST_IDLE;
			end
			ST_DISPOSE: begin
				if (status.sweep_done) state_d = snap_pend_q ? ST_SNAP : ST_IDLE;
			end
			ST_SNAP: begin
				if (status.sweep_done) state_d = ST_IDLE;
			end
			ST_PIXEL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_BOOT: begin
				cmd.sweep_start = 1'b1;
				cmd.sweep_mode  = SW_CLEAR_ALL;
			end
			ST_IDLE: begin
				if (start) begin
					case (op)
						OP_RESTART: begin
							cmd.restart     = 1'b1;
							cmd.sweep_start = 1'b1;
							cmd.sweep_mode  = SW_CLEAR_ALL;
						end
						OP_PALETTE: cmd.load_palette = 1'b1;
						OP_FRAME: begin
							cmd.load_frame = 1'b1;
							if (disp_clear) begin
								cmd.sweep_start = 1'b1;
								cmd.sweep_mode  = SW_CLEAR_RECT;
							end else if (disp_restore) begin
								cmd.sweep_start = 1'b1;
								cmd.sweep_mode  = SW_RESTORE;
							end else if (snap_need) begin
								cmd.sweep_start = 1'b1;
								cmd.sweep_mode  = SW_SNAP;
							end
						end
						OP_PIXEL: cmd.pix_go  = 1'b1;
						OP_READ:  cmd.read_go = 1'b1;
						default:  cmd = '0;
					endcase
				end
			end
			ST_DISPOSE: begin
				if (status.sweep_done && snap_pend_q) begin
					cmd.sweep_start = 1'b1;
					cmd.sweep_mode  = SW_SNAP;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/gfc_datapath.sv */
// ----------------------------------------------------------------------------
// gfc_datapath
// Canvas, snapshot and palette memories, frame cursor and sweep engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_datapath #(
	parameter int CANVAS_W_MAX = 512,
	parameter int CANVAS_H_MAX = 512,
	parameter int PALETTE_SIZE = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gfc_pkg::gfc_cmd_t    cmd,
	output gfc_pkg::gfc_status_t      status,
	input  wire logic                 cfg_wr,
	input  wire logic                 cfg_index,
	input  wire logic [9:0]           cfg_data,
	input  wire logic [7:0]           color_index,
	input  wire logic [23:0]          rgb,
	input  wire logic [15:0]          pos_x,
	input  wire logic [15:0]          pos_y,
	input  wire logic [15:0]          size_w,
	input  wire logic [15:0]          size_h,
	input  wire logic                 transparent_on,
	input  wire logic [8:0]           color_count,
	output logic                      result_valid,
	output logic [31:0]               pixel_abgr
);
	import gfc_pkg::*;

	localparam int XW    = $clog2(CANVAS_W_MAX);
	localparam int YW    = $clog2(CANVAS_H_MAX);
	localparam int WORDS = CANVAS_W_MAX * CANVAS_H_MAX;
	localparam int AW    = $clog2(WORDS);
	localparam int PW    = $clog2(PALETTE_SIZE);
	localparam int EWX   = XW + 1;
	localparam int EWY   = YW + 1;

	// memories
	logic [24:0] canvas_mem [WORDS];
	logic [24:0] saved_mem  [WORDS];
	logic [23:0] palette_mem [PALETTE_SIZE];

	logic [9:0]     cfg_w_q, cfg_h_q;
	logic [EWX-1:0] eff_w;
	logic [EWY-1:0] eff_h;

	logic [15:0] left_q, top_q, w_q, h_q, col_q, row_q;
	logic [7:0]  tidx_q;
	logic        ton_q;
	logic [8:0]  count_q;

	// sweep engine
	logic              sw_act_q;
	sweep_mode_t       mode_q;
	logic [AW-1:0]     lin_q;
	logic [XW-1:0]     cur_x_q, bx_q, lx_q;
	logic [YW-1:0]     cur_y_q, ly_q;
	logic [AW-1:0]     sw_addr;
	logic              gen_last, copy_mode;
	logic              sw_v_s1, sw_last_s1, sw_v_s2, sw_last_s2;
	logic [AW-1:0]     sw_addr_s1, sw_addr_s2;
	logic [16:0]       sum_x, sum_y, end_x, end_y;

	// pixel and read path
	logic              in_frame, clip_ok, idx_ok, opaque_px;
	logic [16:0]       cx, cy;
	logic [AW-1:0]     pix_addr, read_addr;
	logic              pix_we_s1;
	logic [AW-1:0]     pix_addr_s1;
	logic [23:0]       pal_s1;
	logic              rd_in_range, in_range_s1;
	logic [24:0]       canvas_rd_q, saved_rd_q;

	logic              cv_we, cv_re;
	logic [AW-1:0]     cv_waddr, cv_raddr;
	logic [24:0]       cv_wdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_DIM_RESET;
			cfg_h_q <= CFG_DIM_RESET;
		end else if (cfg_wr) begin
			if (cfg_index == REG_CANVAS_W) cfg_w_q <= cfg_data;
			if (cfg_index == REG_CANVAS_H) cfg_h_q <= cfg_data;
		end
	end

	// clamp screen size to 1..max
	always_comb begin
		if (cfg_w_q == 10'd0)                        eff_w = EWX'(1);
		else if ({3'b0, cfg_w_q} > 13'(CANVAS_W_MAX)) eff_w = EWX'(CANVAS_W_MAX);
		else                                          eff_w = EWX'(cfg_w_q);
		if (cfg_h_q == 10'd0)                        eff_h = EWY'(1);
		else if ({3'b0, cfg_h_q} > 13'(CANVAS_H_MAX)) eff_h = EWY'(CANVAS_H_MAX);
		else                                          eff_h = EWY'(cfg_h_q);
	end

	// frame attributes and raster cursor
	assign in_frame = (w_q != 16'd0) && (h_q != 16'd0) && (row_q < h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			top_q   <= '0;
			w_q     <= '0;
			h_q     <= '0;
			tidx_q  <= '0;
			ton_q   <= 1'b0;
			count_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cmd.restart) begin
			left_q <= '0;
			top_q  <= '0;
			w_q    <= '0;
			h_q    <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cmd.load_frame) begin
			left_q  <= pos_x;
			top_q   <= pos_y;
			w_q     <= size_w;
			h_q     <= size_h;
			tidx_q  <= color_index;
			ton_q   <= transparent_on;
			count_q <= color_count;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cmd.pix_go && in_frame) begin
			if (col_q == w_q - 16'd1) begin
				col_q <= '0;
				row_q <= row_q + 16'd1;
			end else begin
				col_q <= col_q + 16'd1;
			end
		end
	end

	// pixel address and write decision
	assign cx        = {1'b0, left_q} + {1'b0, col_q};
	assign cy        = {1'b0, top_q} + {1'b0, row_q};
	assign clip_ok   = (cx < 17'(eff_w)) && (cy < 17'(eff_h));
	assign idx_ok    = ({1'b0, color_index} < count_q) &&
	                   ({1'b0, color_index} < 9'(PALETTE_SIZE));
	assign opaque_px = !(ton_q && (color_index == tidx_q));
	assign pix_addr  = AW'(cy[YW-1:0]) * AW'(CANVAS_W_MAX) + AW'(cx[XW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_we_s1 <= 1'b0;
		end else begin
			pix_we_s1 <= cmd.pix_go && in_frame && clip_ok && idx_ok && opaque_px;
		end
	end

	always_ff @(posedge clk) begin
		pix_addr_s1 <= pix_addr;
	end

	// palette memory
	always_ff @(posedge clk) begin
		if (cmd.load_palette && ({1'b0, color_index} < 9'(PALETTE_SIZE))) begin
			palette_mem[color_index[PW-1:0]] <= rgb;
		end
		if (cmd.pix_go) begin
			pal_s1 <= palette_mem[color_index[PW-1:0]];
		end
	end

	// rectangle bounds, clipped to the screen
	assign sum_x = {1'b0, left_q} + {1'b0, w_q};
	assign sum_y = {1'b0, top_q} + {1'b0, h_q};
	assign end_x = (sum_x <= 17'(eff_w)) ? sum_x : 17'(eff_w);
	assign end_y = (sum_y <= 17'(eff_h)) ? sum_y : 17'(eff_h);

	assign status.rect_empty = !({1'b0, left_q} < 17'(eff_w)) ||
	                           !({1'b0, top_q} < 17'(eff_h)) ||
	                           (w_q == 16'd0) || (h_q == 16'd0);

	// sweep address generation
	assign copy_mode = (mode_q == SW_RESTORE) || (mode_q == SW_SNAP);
	assign sw_addr   = (mode_q == SW_CLEAR_RECT) ?
	                   AW'(cur_y_q) * AW'(CANVAS_W_MAX) + AW'(cur_x_q) : lin_q;
	assign gen_last  = (mode_q == SW_CLEAR_RECT) ?
	                   ((cur_x_q == lx_q) && (cur_y_q == ly_q)) : (lin_q == AW'(WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_act_q <= 1'b0;
			mode_q   <= SW_CLEAR_ALL;
		end else if (cmd.sweep_start) begin
			sw_act_q <= 1'b1;
			mode_q   <= cmd.sweep_mode;
		end else if (sw_act_q && gen_last) begin
			sw_act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_start) begin
			lin_q   <= '0;
			cur_x_q <= XW'(left_q);
			cur_y_q <= YW'(top_q);
			bx_q    <= XW'(left_q);
			lx_q    <= XW'(end_x - 17'd1);
			ly_q    <= YW'(end_y - 17'd1);
		end else if (sw_act_q) begin
			lin_q <= lin_q + AW'(1);
			if (cur_x_q == lx_q) begin
				cur_x_q <= bx_q;
				cur_y_q <= cur_y_q + YW'(1);
			end else begin
				cur_x_q <= cur_x_q + XW'(1);
			end
		end
	end

	// sweep pipeline: s1 clears or reads, s2 writes the copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_v_s1 <= 1'b0;
			sw_v_s2 <= 1'b0;
		end else begin
			sw_v_s1 <= sw_act_q;
			sw_v_s2 <= sw_v_s1 && copy_mode;
		end
	end

	always_ff @(posedge clk) begin
		sw_last_s1 <= gen_last;
		sw_addr_s1 <= sw_addr;
		sw_last_s2 <= sw_last_s1;
		sw_addr_s2 <= sw_addr_s1;
	end

	assign status.sweep_done = (!copy_mode && sw_v_s1 && sw_last_s1) ||
	                           (copy_mode && sw_v_s2 && sw_last_s2);

	// canvas port select
	assign rd_in_range = ({1'b0, pos_x} < 17'(eff_w)) && ({1'b0, pos_y} < 17'(eff_h));
	assign read_addr   = AW'(pos_y[YW-1:0]) * AW'(CANVAS_W_MAX) + AW'(pos_x[XW-1:0]);

	always_comb begin
		cv_we    = 1'b0;
		cv_waddr = pix_addr_s1;
		cv_wdata = {1'b1, pal_s1[7:0], pal_s1[15:8], pal_s1[23:16]};
		if (sw_v_s1 && !copy_mode) begin
			cv_we    = 1'b1;
			cv_waddr = sw_addr_s1;
			cv_wdata = '0;
		end else if (sw_v_s2 && mode_q == SW_RESTORE) begin
			cv_we    = 1'b1;
			cv_waddr = sw_addr_s2;
			cv_wdata = saved_rd_q;
		end else if (pix_we_s1) begin
			cv_we = 1'b1;
		end
	end

	assign cv_re    = cmd.read_go || (sw_v_s1 && mode_q == SW_SNAP);
	assign cv_raddr = cmd.read_go ? read_addr : sw_addr_s1;

	// canvas memory
	always_ff @(posedge clk) begin
		if (cv_we) begin
			canvas_mem[cv_waddr] <= cv_wdata;
		end
		if (cv_re) begin
			canvas_rd_q <= canvas_mem[cv_raddr];
		end
	end

	// snapshot memory
	always_ff @(posedge clk) begin
		if (sw_v_s2 && mode_q == SW_SNAP) begin
			saved_mem[sw_addr_s2] <= canvas_rd_q;
		end
		if (sw_v_s1 && mode_q == SW_RESTORE) begin
			saved_rd_q <= saved_mem[sw_addr_s1];
		end
	end

	// read result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.read_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_go) begin
			in_range_s1 <= rd_in_range;
		end
	end

	assign pixel_abgr = (in_range_s1 && canvas_rd_q[24]) ?
	                    {ALPHA_OPAQUE, canvas_rd_q[23:0]} : 32'd0;

endmodule

`default_nettype wire

/* hw/rtl/gif_frame_compositor.sv */
// ----------------------------------------------------------------------------
// gif_frame_compositor
// Composites indexed GIF frames onto a stored canvas with frame disposal.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low. Pixel items pass
// through a palette lookup, then the canvas write. Canvas work runs through
// the single write port of the canvas memory, one word per cycle: after reset
// and on every restart the whole canvas is cleared; a frame start whose
// predecessor used disposal 2 clears the clipped rectangle, disposal 3
// restores the snapshot. A snapshot is taken on its own or after a clear or a
// restore. A read returns its pixel on pixel_abgr with result_valid high for
// exactly one cycle, the cycle after the item is taken; the receiver cannot
// stall it, so capture it then.
`default_nettype none

module gif_frame_compositor #(
	parameter int CANVAS_W_MAX = 512,
	parameter int CANVAS_H_MAX = 512,
	parameter int PALETTE_SIZE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  color_index,
	input  wire logic [23:0] rgb,
	input  wire logic [15:0] pos_x,
	input  wire logic [15:0] pos_y,
	input  wire logic [15:0] size_w,
	input  wire logic [15:0] size_h,
	input  wire logic        transparent_on,
	input  wire logic [2:0]  disposal,
	input  wire logic [8:0]  color_count,
	output logic             result_valid,
	output logic [31:0]      pixel_abgr,
	input  wire logic        cfg_wr,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_data
);
	import gfc_pkg::*;

	`include "gif_frame_compositor_assert.svh"

	gfc_cmd_t    cmd;
	gfc_status_t status;

	gfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.opcode   (opcode),
		.disposal (disposal),
		.busy     (busy),
		.cmd      (cmd),
		.status   (status)
	);

	gfc_datapath #(
		.CANVAS_W_MAX (CANVAS_W_MAX),
		.CANVAS_H_MAX (CANVAS_H_MAX),
		.PALETTE_SIZE (PALETTE_SIZE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_wr         (cfg_wr),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.color_index    (color_index),
		.rgb            (rgb),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.size_w         (size_w),
		.size_h         (size_h),
		.transparent_on (transparent_on),
		.color_count    (color_count),
		.result_valid   (result_valid),
		.pixel_abgr     (pixel_abgr)
	);

	// a read beat always yields a result in the next cycle, and nothing else does
	`GFC_ASSERT_NXT(a_read_result, clk, arst_n, start && !busy && opcode == OP_READ, result_valid)
	`GFC_ASSERT_IMP(a_result_cause, clk, arst_n, result_valid, $past(start && !busy && opcode == OP_READ))
	// sweeps finish only while the sequencer holds off new items
	`GFC_ASSERT_IMP(a_done_busy, clk, arst_n, status.sweep_done, busy)
	// a restart always starts the canvas clear
	`GFC_ASSERT_NXT(a_restart_busy, clk, arst_n, start && !busy && opcode == OP_RESTART, busy)

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GIF frame compositor: a queue of command beats
// (palette loads, frame starts, pixels, reads, restarts, register writes) is
// driven in random bursts, a local model of the canvas predicts every read
// and a monitor compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import gfc_pkg::*;

	localparam int W_MAX     = 512;
	localparam int H_MAX     = 512;
	localparam int PAL_SLOTS = 256;
	localparam int CYCLE_CAP = 5000000;
	localparam int SETTLE    = 6;

	typedef struct {
		bit          is_cfg;
		bit          is_hold;
		logic        reg_sel;
		bit [9:0]    reg_val;
		opcode_t     op;
		bit [7:0]    ci;
		bit [23:0]   color;
		bit [15:0]   px, py, sw, sh;
		bit          ton;
		bit [2:0]    disp;
		bit [8:0]    cnt;
	} beat_t;

	// dut ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  opcode = OP_RESTART;
	logic [7:0]  color_index = '0;
	logic [23:0] rgb = '0;
	logic [15:0] pos_x = '0, pos_y = '0, size_w = '0, size_h = '0;
	logic        transparent_on = 1'b0;
	logic [2:0]  disposal = '0;
	logic [8:0]  color_count = '0;
	logic        result_valid;
	logic [31:0] pixel_abgr;
	logic        cfg_wr = 1'b0;
	logic        cfg_index = 1'b0;
	logic [9:0]  cfg_data = '0;

	// canvas model
	bit [24:0] canvas_m [W_MAX*H_MAX];
	bit [24:0] saved_m  [W_MAX*H_MAX];
	bit [23:0] pal_m    [PAL_SLOTS];
	bit        snap_held, prior_valid;
	bit [15:0] pr_left, pr_top, pr_w, pr_h;
	bit [2:0]  pr_disp;
	bit [15:0] fr_left, fr_top, fr_w, fr_h;
	bit [7:0]  fr_tidx;
	bit        fr_ton;
	bit [8:0]  fr_cnt;
	bit [31:0] cursor;
	bit [9:0]  reg_w = 10'd512, reg_h = 10'd512;

	beat_t     beat_q[$];
	bit [31:0] abgr_expected[$];
	beat_t     live;
	int        gap_left = 0, burst_left = 8, quiet = 0;
	int        errors = 0, reads_checked = 0, frames_run = 0, pixels_run = 0;
	int        cycles = 0, n_items = 0;
	int        gen_cw = 512, gen_ch = 512;

	gif_frame_compositor dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .color_index(color_index), .rgb(rgb),
		.pos_x(pos_x), .pos_y(pos_y), .size_w(size_w), .size_h(size_h),
		.transparent_on(transparent_on), .disposal(disposal),
		.color_count(color_count), .result_valid(result_valid),
		.pixel_abgr(pixel_abgr), .cfg_wr(cfg_wr), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int clamp_dim(bit [9:0] v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	// clear the disposed rectangle, clipped to the canvas
	function automatic void clear_area(bit [15:0] l, bit [15:0] t, bit [15:0] w, bit [15:0] h);
		int cw, ch, len;
		cw = clamp_dim(reg_w, W_MAX);
		ch = clamp_dim(reg_h, H_MAX);
		if (l >= cw) return;
		len = (l + w <= cw) ? int'(w) : cw - int'(l);
		for (int y = 0; y < h && t + y < ch; y++)
			for (int i = 0; i < len; i++)
				canvas_m[(t + y) * W_MAX + l + i] = '0;
	endfunction

	// advance the canvas model by one accepted beat
	function automatic void composite_beat(beat_t b);
		bit [31:0] total, x, y, cx, cy, v;
		bit [23:0] c;
		case (b.op)
			OP_RESTART: begin
				foreach (canvas_m[i]) canvas_m[i] = '0;
				snap_held = 0;
				prior_valid = 0;
				{fr_left, fr_top, fr_w, fr_h} = '0;
				cursor = 0;
			end
			OP_PALETTE: pal_m[b.ci] = b.color;
			OP_FRAME: begin
				frames_run++;
				if (prior_valid) begin
					if (pr_disp == DISP_CLEAR) clear_area(pr_left, pr_top, pr_w, pr_h);
					else if (pr_disp == DISP_RESTORE) canvas_m = saved_m;
				end
				if (b.disp == DISP_RESTORE) begin
					if (!snap_held) begin
						saved_m = canvas_m;
						snap_held = 1;
					end
				end else
					snap_held = 0;
				{fr_left, fr_top, fr_w, fr_h} = {b.px, b.py, b.sw, b.sh};
				{pr_left, pr_top, pr_w, pr_h} = {b.px, b.py, b.sw, b.sh};
				fr_tidx = b.ci;
				fr_ton = b.ton;
				fr_cnt = b.cnt;
				pr_disp = b.disp;
				prior_valid = 1;
				cursor = 0;
			end
			OP_PIXEL: begin
				pixels_run++;
				total = 32'(fr_w) * 32'(fr_h);
				if (total != 0 && cursor < total) begin
					x = cursor % fr_w;
					y = cursor / fr_w;
					cursor++;
					cx = fr_left + x;
					cy = fr_top + y;
					if (cx < clamp_dim(reg_w, W_MAX) && cy < clamp_dim(reg_h, H_MAX) &&
					    b.ci < fr_cnt && !(fr_ton && b.ci == fr_tidx)) begin
						c = pal_m[b.ci];
						canvas_m[cy * W_MAX + cx] = {1'b1, c[7:0], c[15:8], c[23:16]};
					end
				end
			end
			OP_READ: begin
				v = 0;
				if (b.px < clamp_dim(reg_w, W_MAX) && b.py < clamp_dim(reg_h, H_MAX) &&
				    canvas_m[b.py * W_MAX + b.px][24])
					v = {ALPHA_OPAQUE, canvas_m[b.py * W_MAX + b.px][23:0]};
				abgr_expected.push_back(v);
			end
			default: ;
		endcase
	endfunction

	// stimulus builders
	function automatic beat_t mk(opcode_t op);
		beat_t b;
		b = '{op: OP_RESTART, default: '0};
		b.op = op;
		b.ci = 8'($urandom);
		b.color = 24'($urandom);
		b.px = 16'($urandom);
		b.py = 16'($urandom);
		b.sw = 16'($urandom);
		b.sh = 16'($urandom);
		b.ton = 1'($urandom);
		b.disp = 3'($urandom);
		b.cnt = 9'($urandom_range(0, 256));
		return b;
	endfunction

	function automatic void put(beat_t b);
		beat_q.push_back(b);
		n_items++;
	endfunction

	function automatic void put_pal(bit [7:0] slot, bit [23:0] c);
		beat_t b;
		b = mk(OP_PALETTE);
		b.ci = slot;
		b.color = c;
		put(b);
	endfunction

	function automatic void put_pix(bit [7:0] idx);
		beat_t b;
		b = mk(OP_PIXEL);
		b.ci = idx;
		put(b);
	endfunction

	function automatic void put_read(bit [15:0] x, bit [15:0] y);
		beat_t b;
		b = mk(OP_READ);
		b.px = x;
		b.py = y;
		put(b);
	endfunction

	function automatic void put_frame(bit [15:0] x, bit [15:0] y, bit [15:0] w, bit [15:0] h,
		bit [8:0] cnt, bit ton, bit [7:0] tidx, bit [2:0] d);
		beat_t b;
		b = mk(OP_FRAME);
		{b.px, b.py, b.sw, b.sh, b.cnt, b.ton, b.ci, b.disp} = {x, y, w, h, cnt, ton, tidx, d};
		put(b);
	endfunction

	function automatic void put_hold();
		beat_t b;
		b = '{op: OP_RESTART, default: '0};
		b.is_hold = 1;
		beat_q.push_back(b);
	endfunction

	function automatic void put_cfg(bit [9:0] w, bit [9:0] h);
		beat_t b;
		b = '{op: OP_RESTART, default: '0};
		b.is_cfg = 1;
		b.reg_sel = REG_CANVAS_W;
		b.reg_val = w;
		beat_q.push_back(b);
		b.reg_sel = REG_CANVAS_H;
		b.reg_val = h;
		beat_q.push_back(b);
		gen_cw = clamp_dim(w, W_MAX);
		gen_ch = clamp_dim(h, H_MAX);
	endfunction

	function automatic bit [15:0] near_pos(int lim);
		return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, lim + 2));
	endfunction

	// one well-formed frame with random content, some noise around it
	function automatic void gen_frame();
		bit [2:0]  d;
		bit [15:0] x, y, w, h;
		bit [7:0]  tidx;
		bit        big;
		int        npx;
		d = ($urandom_range(0, 9) < 4) ? DISP_CLEAR : 3'($urandom_range(4, 9) % 8);
		if (d == DISP_RESTORE || d == DISP_CLEAR) d = 3'd0;
		if ($urandom_range(0, 9) < 4) d = DISP_CLEAR;
		big = (d != DISP_CLEAR) && ($urandom_range(0, 9) == 0);
		w = big ? 16'($urandom) : 16'($urandom_range(1, 12));
		h = big ? 16'($urandom) : 16'($urandom_range(1, 8));
		x = near_pos(gen_cw);
		y = near_pos(gen_ch);
		tidx = 8'($urandom);
		put_frame(x, y, w, h, ($urandom_range(0, 9) < 7) ? 9'd256 : 9'($urandom_range(0, 256)),
			1'($urandom), tidx, d);
		npx = big ? int'($urandom_range(3, 15)) : int'(w) * int'(h) + int'($urandom_range(0, 2));
		if (!big && $urandom_range(0, 7) == 0) npx = int'($urandom_range(0, npx));
		for (int i = 0; i < npx; i++) begin
			put_pix(($urandom_range(0, 4) == 0) ? tidx : 8'($urandom));
			if ($urandom_range(0, 19) == 0)
				put_read(16'(x + $urandom_range(0, 11)), 16'(y + $urandom_range(0, 7)));
			if ($urandom_range(0, 29) == 0) put_pal(8'($urandom), 24'($urandom));
		end
		for (int i = $urandom_range(1, 4); i > 0; i--)
			put_read(16'(x + $urandom_range(0, 12)), 16'(y + $urandom_range(0, 8)));
		if ($urandom_range(0, 9) == 0) put_read(near_pos(gen_cw), near_pos(gen_ch));
	endfunction

	// driver: launch beats in bursts, apply register writes only when idle
	always @(posedge clk or negedge arst_n) begin
		bit    slot_free, launch, wr;
		beat_t head;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_wr <= 1'b0;
		end else begin
			launch = 0;
			wr = 0;
			if (start && !busy) composite_beat(live);
			if (start || busy) quiet = 0;
			else quiet++;
			slot_free = !start || !busy;
			if (slot_free && beat_q.size() > 0) begin
				head = beat_q[0];
				if (head.is_cfg || head.is_hold) begin
					if (quiet >= SETTLE && abgr_expected.size() == 0) begin
						void'(beat_q.pop_front());
						if (head.is_cfg) begin
							wr = 1;
							if (head.reg_sel == REG_CANVAS_W) reg_w = head.reg_val;
							else reg_h = head.reg_val;
							cfg_index <= head.reg_sel;
							cfg_data <= head.reg_val;
						end
					end
				end else if (gap_left > 0)
					gap_left--;
				else begin
					void'(beat_q.pop_front());
					launch = 1;
					live = head;
					if (--burst_left <= 0) begin
						burst_left = $urandom_range(1, 60);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					end
				end
			end
			if (slot_free) start <= launch;
			cfg_wr <= wr;
			if (launch) begin
				opcode <= head.op;
				color_index <= head.ci;
				rgb <= head.color;
				pos_x <= head.px;
				pos_y <= head.py;
				size_w <= head.sw;
				size_h <= head.sh;
				transparent_on <= head.ton;
				disposal <= head.disp;
				color_count <= head.cnt;
			end
		end
	end

	// monitor: check each read beat against the oldest prediction
	always @(posedge clk) begin
		bit [31:0] want;
		if (arst_n && result_valid) begin
			if (abgr_expected.size() == 0) begin
				errors++;
				if (errors <= 10) $display("tb_top: unexpected result pixel_abgr=%h", pixel_abgr);
			end else begin
				want = abgr_expected.pop_front();
				reads_checked++;
				if (pixel_abgr !== want) begin
					errors++;
					if (errors <= 10)
						$display("tb_top: pixel_abgr mismatch: expected %h, got %h", want, pixel_abgr);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		bit [9:0] dims [6][2];
		dims = '{'{10'd0, 10'd0}, '{10'd1023, 10'd1023}, '{10'd37, 10'd23},
			'{10'd512, 10'd1}, '{10'd1, 10'd512}, '{10'd0, 10'd0}};
		dims[5][0] = 10'($urandom_range(2, 511));
		dims[5][1] = 10'($urandom_range(2, 511));

		// directed: palette extremes, clipping, transparency, both disposals, restart
		put_pal(8'd0, 24'hffffff);
		put_pal(8'd255, 24'h123456);
		put_pal(8'd1, 24'h000000);
		put_pal(8'd2, 24'ha5c3f0);
		put_pix(8'd0);
		put_read(16'd0, 16'd0);
		put_frame(16'd0, 16'd0, 16'd3, 16'd2, 9'd256, 1'b1, 8'd2, DISP_CLEAR);
		put_pix(8'd0); put_pix(8'd255); put_pix(8'd2);
		put_pix(8'd1); put_pix(8'd0); put_pix(8'd255); put_pix(8'd0);
		put_read(16'd1, 16'd0);
		put_read(16'd2, 16'd0);
		put_read(16'hffff, 16'hffff);
		put_frame(16'd510, 16'd511, 16'd4, 16'd1, 9'd2, 1'b0, 8'd0, DISP_RESTORE);
		put_pix(8'd0); put_pix(8'd1); put_pix(8'd255); put_pix(8'd0);
		put_read(16'd511, 16'd511);
		put_read(16'd0, 16'd0);
		put_frame(16'd0, 16'd0, 16'd1, 16'd1, 9'd256, 1'b0, 8'd0, 3'd0);
		put_pix(8'd255);
		put_read(16'd0, 16'd0);
		put_read(16'd511, 16'd511);
		put(mk(OP_RESTART));
		put_read(16'd0, 16'd0);
		put_hold();

		// random: fill the palette, then frames under several canvas sizes
		for (int i = 0; i < PAL_SLOTS; i++) put_pal(8'(i), 24'($urandom));
		for (int p = 0; p < 7; p++) begin
			if (p > 0) put_cfg(dims[p - 1][0], dims[p - 1][1]);
			while (n_items < 280 + 90 * (p + 1)) gen_frame();
			if (p == 3) put_hold();
		end
		put_cfg(10'd512, 10'd512);
		while (n_items < 950) gen_frame();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (beat_q.size() == 0);
		while (start || abgr_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("tb_top: %0d beats, %0d frames, %0d pixels, %0d reads checked",
			n_items, frames_run, pixels_run, reads_checked);
		$display("tb_top: canvas sizes swept from clamped 1x1 to 512x512, %0d failures", errors);
		if (errors == 0 && abgr_expected.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

/* gif_frame_compositor.f */
+incdir+hw/rtl
hw/rtl/gfc_pkg.sv
hw/rtl/gfc_ctrl.sv
hw/rtl/gfc_datapath.sv
hw/rtl/gif_frame_compositor.sv
test/tb_top.sv
